/* rtl/orlq_pkg.sv */
// orlq_pkg: shared types and constants of the ordered row lock queue
// depends on nothing
package orlq_pkg;
  localparam int unsigned QueueDepth = 16;
  localparam int unsigned CntW = $clog2(QueueDepth + 1);
  localparam int unsigned PosW = $clog2(QueueDepth);

  typedef enum logic [2:0] {
    EV_GRANTED        = 3'd0,
    EV_WAIT           = 3'd1,
    EV_REVOKED        = 3'd2,
    EV_WAITER_GRANTED = 3'd3,
    EV_RELEASED       = 3'd4,
    EV_NOT_OWNER      = 3'd5,
    EV_FULL           = 3'd6
  } event_e;

  typedef enum logic [1:0] {
    MODE_NONE   = 2'd0,
    MODE_SHARED = 2'd1,
    MODE_EXCL   = 2'd2
  } mode_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DECIDE,
    ST_SCAN_WAIT,
    ST_SCAN_OWN,
    ST_REVOKE,
    ST_FINAL,
    ST_PROMOTE
  } state_e;

  // per-cell control from the sequencer
  typedef struct packed {
    logic            ins;
    logic [PosW-1:0] ins_pos;
    logic            rem;
    logic [PosW-1:0] rem_pos;
    logic [31:0]     id;
    logic            excl;
  } cell_ctrl_t;
endpackage

/* rtl/orlq_cell.sv */
// orlq_cell: one queue slot, takes its neighbour's entry on insert or removal
// depends on orlq_pkg
module orlq_cell (
  input  logic                clk_i,
  input  orlq_pkg::cell_ctrl_t ctrl_i,
  input  logic [orlq_pkg::PosW-1:0] pos_i,
  input  logic [31:0]         prev_id_i,
  input  logic                prev_excl_i,
  input  logic [31:0]         next_id_i,
  input  logic                next_excl_i,
  output logic [31:0]         id_o,
  output logic                excl_o
);
  import orlq_pkg::*;
  logic [31:0] id_q;
  logic        excl_q;

  always_ff @(posedge clk_i) begin
    if (ctrl_i.ins) begin
      if (pos_i == ctrl_i.ins_pos) begin
        id_q   <= ctrl_i.id;
        excl_q <= ctrl_i.excl;
      end else if (pos_i > ctrl_i.ins_pos) begin
        id_q   <= prev_id_i;
        excl_q <= prev_excl_i;
      end
    end else if (ctrl_i.rem && pos_i >= ctrl_i.rem_pos) begin
      id_q   <= next_id_i;
      excl_q <= next_excl_i;
    end
  end

  assign id_o   = id_q;
  assign excl_o = excl_q;
endmodule

/* rtl/ordered_row_lock_queue.sv */
// ordered_row_lock_queue: top level, sequencer over a row of queue cells
// depends on orlq_pkg and orlq_cell
//
//  channel | valid  | stall  | fields
//  request | in_valid_i  | in_stall_o  | func_i txn_id_i want_exclusive_i
//  event   | out_valid_o | out_stall_i | event_txn_id_o event_kind_o last_o
//
// a request holds the input while it passes idle, decide, the slot scan of an
// acquire that finds owners, a revoke per revoked owner, the final event and
// a promotion per promoted waiter; events go out one per cycle unless stalled.
// one request is in flight at a time; stall on the event side holds the word
// and holds back every further event while it lasts.
// reset empties the queue by its counters alone.
module ordered_row_lock_queue (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic        func_i,
  input  logic [31:0] txn_id_i,
  input  logic        want_exclusive_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [31:0] event_txn_id_o,
  output logic [2:0]  event_kind_o,
  output logic        last_o
);
  import orlq_pkg::*;

  state_e state_q, state_d;
  logic [CntW-1:0] entry_q, entry_d, owner_q, owner_d, p_q, p_d;
  logic [CntW-1:0] pos_q, pos_d, fown_q, fown_d;
  mode_e mode_q, mode_d;
  logic fmode_q, fmode_d;
  event_e fkind_q, fkind_d;
  logic func_q, excl_q;
  logic [31:0] id_q;
  logic ov_q, ov_d, olast_q, olast_d;
  logic [31:0] oid_q, oid_d;
  event_e okind_q, okind_d;
  cell_ctrl_t ctrl;

  logic [31:0] ids [QueueDepth];
  logic        exs [QueueDepth];

  for (genvar g = 0; g < QueueDepth; g++) begin : g_cell
    localparam int Gp = (g == 0) ? 0 : g - 1;
    localparam int Gn = (g == QueueDepth - 1) ? g : g + 1;
    orlq_cell u_cell (
      .clk_i, .ctrl_i(ctrl), .pos_i(PosW'(g)),
      .prev_id_i(ids[Gp]), .prev_excl_i(exs[Gp]),
      .next_id_i(ids[Gn]), .next_excl_i(exs[Gn]),
      .id_o(ids[g]), .excl_o(exs[g])
    );
  end

  logic [PosW-1:0] pidx, nidx;
  logic [CntW-1:0] nsel;
  logic [31:0] cur_id;
  logic        cur_ex, nxt_ex, clash, out_free, rel_more, pro_more, last_rev;
  assign pidx     = p_q[PosW-1:0];
  assign nsel     = (state_q == ST_PROMOTE) ? p_q + 1'b1 : owner_q;
  assign nidx     = nsel[PosW-1:0];
  assign cur_id   = ids[pidx];
  assign cur_ex   = exs[pidx];
  assign nxt_ex   = exs[nidx];
  assign clash    = (mode_q == MODE_EXCL) || (mode_q == MODE_SHARED && excl_q);
  assign out_free = !ov_q || !out_stall_i;
  assign in_stall_o = (state_q != ST_IDLE);
  // head waiter can be promoted if the released owner was the last, or both modes are shared
  assign rel_more = (owner_q < entry_q) &&
                    (owner_q == CntW'(1) || !(mode_q == MODE_EXCL || nxt_ex));
  assign pro_more = (p_q + 1'b1 < entry_q) && !cur_ex && !nxt_ex;
  assign last_rev = (p_q + 1'b1 == owner_q);

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: if (in_valid_i) state_d = ST_DECIDE;
      ST_DECIDE: begin
        if (func_q) begin
          if (!(p_q < owner_q && cur_id != id_q)) state_d = ST_FINAL;
        end else if (entry_q == CntW'(QueueDepth) || owner_q == '0) begin
          state_d = ST_FINAL;
        end else if (cur_id < id_q) begin
          state_d = ST_SCAN_WAIT;
        end else begin
          state_d = ST_SCAN_OWN;
        end
      end
      ST_SCAN_WAIT: if (!(p_q < entry_q && cur_id < id_q)) state_d = ST_FINAL;
      ST_SCAN_OWN: if (!(p_q < owner_q && cur_id < id_q)) begin
        state_d = clash ? ST_REVOKE : ST_FINAL;
      end
      ST_REVOKE: if (out_free && last_rev) state_d = ST_FINAL;
      ST_FINAL: if (out_free) begin
        state_d = (fkind_q == EV_RELEASED && rel_more) ? ST_PROMOTE : ST_IDLE;
      end
      ST_PROMOTE: if (out_free && !pro_more) state_d = ST_IDLE;
      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    entry_d = entry_q; owner_d = owner_q; mode_d = mode_q; p_d = p_q;
    pos_d = pos_q; fown_d = fown_q; fmode_d = fmode_q; fkind_d = fkind_q;
    ov_d = ov_q && out_stall_i; oid_d = oid_q; okind_d = okind_q; olast_d = olast_q;
    ctrl = '{ins: 1'b0, ins_pos: pos_q[PosW-1:0], rem: 1'b0, rem_pos: pos_q[PosW-1:0],
             id: id_q, excl: excl_q};
    unique case (state_q)
      ST_IDLE: if (in_valid_i) begin
        p_d = (func_i || owner_q == '0) ? '0 : owner_q - 1'b1;
      end
      ST_DECIDE: begin
        if (func_q) begin
          if (p_q < owner_q && cur_id != id_q) begin
            p_d = p_q + 1'b1;
          end else begin
            pos_d = p_q;
            fkind_d = (p_q < owner_q) ? EV_RELEASED : EV_NOT_OWNER;
          end
        end else if (entry_q == CntW'(QueueDepth)) begin
          fkind_d = EV_FULL;
        end else if (owner_q == '0) begin
          pos_d = '0; fkind_d = EV_GRANTED; fown_d = CntW'(1); fmode_d = 1'b1;
        end else if (cur_id < id_q) begin
          p_d = owner_q;
        end else begin
          p_d = '0;
        end
      end
      ST_SCAN_WAIT: begin
        if (p_q < entry_q && cur_id < id_q) begin
          p_d = p_q + 1'b1;
        end else begin
          pos_d = p_q;
          if (!clash && p_q == owner_q) begin
            fkind_d = EV_GRANTED; fown_d = owner_q + 1'b1; fmode_d = 1'b1;
          end else begin
            fkind_d = EV_WAIT; fown_d = owner_q; fmode_d = 1'b0;
          end
        end
      end
      ST_SCAN_OWN: begin
        if (p_q < owner_q && cur_id < id_q) begin
          p_d = p_q + 1'b1;
        end else begin
          pos_d = p_q;
          if (!clash) begin
            fkind_d = EV_GRANTED; fown_d = owner_q + 1'b1; fmode_d = 1'b1;
          end else if (p_q != '0) begin
            fkind_d = EV_WAIT; fown_d = p_q; fmode_d = 1'b0;
          end else begin
            fkind_d = EV_GRANTED; fown_d = CntW'(1); fmode_d = 1'b1;
          end
        end
      end
      ST_REVOKE: if (out_free) begin
        ov_d = 1'b1; oid_d = cur_id; okind_d = EV_REVOKED; olast_d = 1'b0;
        p_d = p_q + 1'b1;
      end
      ST_FINAL: if (out_free) begin
        ov_d = 1'b1; oid_d = id_q; okind_d = fkind_q; olast_d = 1'b1;
        if (fkind_q == EV_RELEASED) begin
          ctrl.rem = 1'b1;
          entry_d = entry_q - 1'b1; owner_d = owner_q - 1'b1;
          if (owner_q == CntW'(1)) mode_d = MODE_NONE;
          p_d = owner_q - 1'b1;
          olast_d = !rel_more;
        end else if (fkind_q inside {EV_GRANTED, EV_WAIT}) begin
          ctrl.ins = 1'b1;
          entry_d = entry_q + 1'b1; owner_d = fown_q;
          if (fmode_q) mode_d = excl_q ? MODE_EXCL : MODE_SHARED;
        end
      end
      ST_PROMOTE: if (out_free) begin
        ov_d = 1'b1; oid_d = cur_id; okind_d = EV_WAITER_GRANTED;
        mode_d = cur_ex ? MODE_EXCL : MODE_SHARED;
        owner_d = owner_q + 1'b1; p_d = p_q + 1'b1;
        olast_d = !pro_more;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE; entry_q <= '0; owner_q <= '0; mode_q <= MODE_NONE;
      ov_q <= 1'b0; p_q <= '0;
    end else begin
      state_q <= state_d; entry_q <= entry_d; mode_q <= mode_d; ov_q <= ov_d;
      owner_q <= owner_d; p_q <= p_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == ST_IDLE && in_valid_i) begin
      func_q <= func_i; id_q <= txn_id_i; excl_q <= want_exclusive_i;
    end
    oid_q <= oid_d; okind_q <= okind_d; olast_q <= olast_d;
    pos_q <= pos_d; fown_q <= fown_d; fmode_q <= fmode_d; fkind_q <= fkind_d;
  end

  assign out_valid_o    = ov_q;
  assign event_txn_id_o = oid_q;
  assign event_kind_o   = okind_q;
  assign last_o         = olast_q;
endmodule
